// File: design/rmq_pkg.sv
`default_nettype none
package rmq_pkg;

	// Number of quotient bits resolved by the divider pipeline
	localparam int QB = 16;

	typedef enum logic [1:0] {
		BR_TRACE = 2'd0,
		BR_X     = 2'd1,
		BR_Y     = 2'd2,
		BR_Z     = 2'd3
	} br_t;

	// Branch and the three off-diagonal numerators
	typedef struct packed {
		br_t                br;
		logic signed [16:0] n0;
		logic signed [16:0] n1;
		logic signed [16:0] n2;
	} rmq_side_t;

	// Status carried alongside the quotient lanes
	typedef struct packed {
		br_t        br;
		logic       fault;
		logic [2:0] neg;
		logic [2:0] ovf;
	} rmq_stat_t;

endpackage
`default_nettype wire

// File: design/rotation_matrix_to_quaternion.sv
`default_nettype none
// Channel  Direction  Handshake            Payload
// input    in         in_valid / in_stall  m_r1c1 .. m_r3c3, signed fixed point
// output   out        out_valid/ out_stall quat_w/x/y/z, branch_taken, divide_fault
//
// One transaction enters per cycle while in_stall is low. The pipeline has
// one front stage, NS square-root stages (one root bit each),
// one divider prepare stage, 16 divider stages (one quotient bit each) and
// the output register. Reset clears only the valid bits. While a finished
// transaction is held at the output under stall, the whole pipeline holds and
// in_stall is raised; nothing is dropped or repeated.
module rotation_matrix_to_quaternion #(
	parameter int FRAC_BITS = 14
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] m_r1c1,
	input  wire logic signed [15:0] m_r1c2,
	input  wire logic signed [15:0] m_r1c3,
	input  wire logic signed [15:0] m_r2c1,
	input  wire logic signed [15:0] m_r2c2,
	input  wire logic signed [15:0] m_r2c3,
	input  wire logic signed [15:0] m_r3c1,
	input  wire logic signed [15:0] m_r3c2,
	input  wire logic signed [15:0] m_r3c3,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      quat_w,
	output logic signed [15:0]      quat_x,
	output logic signed [15:0]      quat_y,
	output logic signed [15:0]      quat_z,
	output logic [1:0]              branch_taken,
	output logic                    divide_fault
);
	import rmq_pkg::*;

	// Radicand width: one plus three diagonal terms, never negative after clamp
	localparam int RW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
	localparam int SV = RW + FRAC_BITS;
	// Root width
	localparam int NS = (SV + 1) / 2;

	logic adv;

	// Advance unless the output register holds a transaction that is stalled
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	logic          f_vld;
	logic [RW-1:0] f_rad;
	rmq_side_t     f_side;

	rmq_front #(.FRAC_BITS(FRAC_BITS), .RW(RW)) u_front (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_vld(in_valid),
		.m11(m_r1c1), .m12(m_r1c2), .m13(m_r1c3),
		.m21(m_r2c1), .m22(m_r2c2), .m23(m_r2c3),
		.m31(m_r3c1), .m32(m_r3c2), .m33(m_r3c3),
		.vld_s1(f_vld), .rad_s1(f_rad), .side_s1(f_side)
	);

	logic          s_vld;
	logic [NS-1:0] s_root;
	rmq_side_t     s_side;

	rmq_sqrt #(.FRAC_BITS(FRAC_BITS), .RW(RW), .NS(NS)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_vld(f_vld),
		.rad(f_rad), .side(f_side),
		.out_vld(s_vld), .root(s_root), .out_side(s_side)
	);

	logic          d_vld;
	logic [QB-1:0] d_quo [3];
	logic [NS-1:0] d_diag;
	rmq_stat_t     d_stat;

	rmq_div #(.FRAC_BITS(FRAC_BITS), .NS(NS)) u_div (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_vld(s_vld),
		.root(s_root), .side(s_side),
		.out_vld(d_vld), .quo(d_quo), .diag(d_diag), .stat(d_stat)
	);

	// Saturate the signed quotients and the diagonal term, then place them
	logic signed [15:0] oth [3];
	logic signed [15:0] dg;
	logic signed [15:0] qv  [4];
	logic [16:0]        mg;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			// overflow means the magnitude is at least 2^16: saturate
			mg = d_stat.ovf[i] ? 17'h1FFFF : {1'b0, d_quo[i]};
			if (d_stat.neg[i]) begin
				oth[i] = (mg > 17'd32768) ? 16'sh8000 : 16'(-mg);
			end else begin
				oth[i] = (mg > 17'd32767) ? 16'sh7FFF : mg[15:0];
			end
		end
		dg = (32'(d_diag) > 32'd32767) ? 16'sh7FFF : 16'(d_diag);
		case (d_stat.br)
			BR_TRACE: begin
				qv[0] = dg;     qv[1] = oth[0]; qv[2] = oth[1]; qv[3] = oth[2];
			end
			BR_X: begin
				qv[0] = oth[0]; qv[1] = dg;     qv[2] = oth[1]; qv[3] = oth[2];
			end
			BR_Y: begin
				qv[0] = oth[0]; qv[1] = oth[1]; qv[2] = dg;     qv[3] = oth[2];
			end
			BR_Z: begin
				qv[0] = oth[0]; qv[1] = oth[1]; qv[2] = oth[2]; qv[3] = dg;
			end
			default: begin
				qv[0] = dg;     qv[1] = oth[0]; qv[2] = oth[1]; qv[3] = oth[2];
			end
		endcase
		// zero divisor: drop every component
		if (d_stat.fault) begin
			for (int i = 0; i < 4; i++) begin
				qv[i] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= d_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			quat_w       <= qv[0];
			quat_x       <= qv[1];
			quat_y       <= qv[2];
			quat_z       <= qv[3];
			branch_taken <= d_stat.br;
			divide_fault <= d_stat.fault;
		end
	end

endmodule
`default_nettype wire

// File: design/rmq_front.sv
`default_nettype none
module rmq_front #(
	parameter int FRAC_BITS = 14,
	parameter int RW        = 19
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  wire logic                in_vld,
	input  wire logic signed [15:0]  m11,
	input  wire logic signed [15:0]  m12,
	input  wire logic signed [15:0]  m13,
	input  wire logic signed [15:0]  m21,
	input  wire logic signed [15:0]  m22,
	input  wire logic signed [15:0]  m23,
	input  wire logic signed [15:0]  m31,
	input  wire logic signed [15:0]  m32,
	input  wire logic signed [15:0]  m33,
	output logic                     vld_s1,
	output logic [RW-1:0]            rad_s1,
	output rmq_pkg::rmq_side_t       side_s1
);
	import rmq_pkg::*;

	localparam int RS = RW + 1;

	function automatic logic signed [17:0] sx18(input logic signed [15:0] a);
		return {{2{a[15]}}, a};
	endfunction

	function automatic logic signed [16:0] sx17(input logic signed [15:0] a);
		return {a[15], a};
	endfunction

	logic signed [17:0] tr;
	logic signed [17:0] t;
	logic signed [RS-1:0] rad_full;
	rmq_side_t side_d;

	always_comb begin
		tr = sx18(m11) + sx18(m22) + sx18(m33);
		if (!tr[17] && (tr != 18'sd0)) begin
			side_d.br = BR_TRACE;
			t = tr;
			side_d.n0 = sx17(m23) - sx17(m32);
			side_d.n1 = sx17(m31) - sx17(m13);
			side_d.n2 = sx17(m12) - sx17(m21);
		end else if ((m11 > m22) && (m11 > m33)) begin
			side_d.br = BR_X;
			t = sx18(m11) - sx18(m22) - sx18(m33);
			side_d.n0 = sx17(m23) - sx17(m32);
			side_d.n1 = sx17(m21) + sx17(m12);
			side_d.n2 = sx17(m31) + sx17(m13);
		end else if (m22 > m33) begin
			side_d.br = BR_Y;
			t = sx18(m22) - sx18(m11) - sx18(m33);
			side_d.n0 = sx17(m31) - sx17(m13);
			side_d.n1 = sx17(m21) + sx17(m12);
			side_d.n2 = sx17(m32) + sx17(m23);
		end else begin
			side_d.br = BR_Z;
			t = sx18(m33) - sx18(m11) - sx18(m22);
			side_d.n0 = sx17(m12) - sx17(m21);
			side_d.n1 = sx17(m31) + sx17(m13);
			side_d.n2 = sx17(m32) + sx17(m23);
		end
		rad_full = (RS'(1) << FRAC_BITS) + {{(RS-18){t[17]}}, t};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// clamp a negative radicand to zero
			rad_s1  <= rad_full[RS-1] ? '0 : rad_full[RW-1:0];
			side_s1 <= side_d;
		end
	end

endmodule
`default_nettype wire

// File: design/rmq_sqrt.sv
`default_nettype none
module rmq_sqrt #(
	parameter int FRAC_BITS = 14,
	parameter int RW        = 19,
	parameter int NS        = 17
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  wire logic                in_vld,
	input  wire logic [RW-1:0]       rad,
	input  wire rmq_pkg::rmq_side_t  side,
	output logic                     out_vld,
	output logic [NS-1:0]            root,
	output rmq_pkg::rmq_side_t       out_side
);
	import rmq_pkg::*;

	localparam int SV = RW + FRAC_BITS;

	logic [SV-1:0] v_s   [0:NS];
	logic [SV-1:0] res_s [0:NS];
	rmq_side_t     side_s [0:NS];
	logic          vld_s [0:NS];

	assign v_s[0]    = {rad, FRAC_BITS'(0)};
	assign res_s[0]  = '0;
	assign side_s[0] = side;
	assign vld_s[0]  = in_vld;

	for (genvar k = 0; k < NS; k++) begin : g_stg
		localparam int SH = 2 * (NS - 1 - k);
		logic [SV:0]   trial;
		logic          take;
		logic [SV-1:0] v_nx;
		logic [SV-1:0] res_nx;

		always_comb begin
			trial  = {1'b0, res_s[k]} + ((SV + 1)'(1) << SH);
			take   = {1'b0, v_s[k]} >= trial;
			v_nx   = take ? (v_s[k] - trial[SV-1:0]) : v_s[k];
			res_nx = take ? ((res_s[k] >> 1) + (SV'(1) << SH)) : (res_s[k] >> 1);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				v_s[k+1]    <= v_nx;
				res_s[k+1]  <= res_nx;
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_vld  = vld_s[NS];
	assign root     = res_s[NS][NS-1:0];
	assign out_side = side_s[NS];

endmodule
`default_nettype wire

// File: design/rmq_div.sv
`default_nettype none
module rmq_div #(
	parameter int FRAC_BITS = 14,
	parameter int NS        = 17
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  wire logic                in_vld,
	input  wire logic [NS-1:0]       root,
	input  wire rmq_pkg::rmq_side_t  side,
	output logic                     out_vld,
	output logic [rmq_pkg::QB-1:0]   quo [3],
	output logic [NS-1:0]            diag,
	output rmq_pkg::rmq_stat_t       stat
);
	import rmq_pkg::*;

	localparam int DW = FRAC_BITS + 18;
	localparam int W  = (DW > NS + QB + 1) ? DW : NS + QB + 1;

	logic [W-1:0]  rem_s  [0:QB][3];
	logic [QB-1:0] q_s    [0:QB][3];
	logic [NS:0]   d_s    [0:QB];
	logic [NS-1:0] diag_s [0:QB];
	rmq_stat_t     stat_s [0:QB];
	logic          vld_s  [0:QB];

	// Prepare dividends, divisor, overflow and diagonal term
	logic signed [16:0] n    [3];
	logic [16:0]        mag  [3];
	logic [W-1:0]       dvd  [3];
	logic [NS:0]        dvs;
	logic [NS:0]        rp1;
	rmq_stat_t          st_d;

	always_comb begin
		n[0] = side.n0;
		n[1] = side.n1;
		n[2] = side.n2;
		dvs  = {root, 1'b0};
		rp1  = {1'b0, root} + (NS + 1)'(1);
		st_d.br    = side.br;
		st_d.fault = (root == '0);
		for (int i = 0; i < 3; i++) begin
			mag[i]      = n[i][16] ? 17'(-n[i]) : 17'(n[i]);
			dvd[i]      = (W'(mag[i]) << FRAC_BITS) + W'(root);
			st_d.neg[i] = n[i][16];
			st_d.ovf[i] = dvd[i] >= (W'(dvs) << QB);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				rem_s[0][i] <= dvd[i];
				q_s[0][i]   <= '0;
			end
			d_s[0]    <= dvs;
			diag_s[0] <= rp1[NS:1];
			stat_s[0] <= st_d;
		end
	end

	// One quotient bit per stage, most significant first
	for (genvar j = 0; j < QB; j++) begin : g_stg
		localparam int SH = QB - 1 - j;
		logic [W-1:0] trial;
		logic [2:0]   ge;

		always_comb begin
			trial = W'(d_s[j]) << SH;
			for (int i = 0; i < 3; i++) begin
				ge[i] = rem_s[j][i] >= trial;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (adv) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int i = 0; i < 3; i++) begin
					rem_s[j+1][i] <= ge[i] ? (rem_s[j][i] - trial) : rem_s[j][i];
					q_s[j+1][i]   <= {q_s[j][i][QB-2:0], ge[i]};
				end
				d_s[j+1]    <= d_s[j];
				diag_s[j+1] <= diag_s[j];
				stat_s[j+1] <= stat_s[j];
			end
		end
	end

	assign out_vld = vld_s[QB];
	assign quo     = q_s[QB];
	assign diag    = diag_s[QB];
	assign stat    = stat_s[QB];

endmodule
`default_nettype wire
